[rtl/dqr_pkg.sv]
// Shared types and constants for the DNS query reply rewriter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package dqr_pkg;

  localparam int MAX_DATAGRAM = 512;

  localparam int CNT_W = $clog2(MAX_DATAGRAM + 1);
  localparam int LBL_W = $clog2(MAX_DATAGRAM + 257);
  localparam int CMP_W = ((CNT_W > 10) ? CNT_W : 10) + 1;

  localparam int HEADER_LEN = 12;
  localparam int ANSWER_LEN = 16;
  localparam int QUESTION_TAIL = 5;

  localparam int OFFSET_W = 9;
  localparam int LENGTH_W = 10;
  localparam int CFG_W = 32;

  localparam int JOB_DEPTH = 4;
  localparam int RES_DEPTH = 4;

  localparam logic [0:0] REG_ANSWER_ADDRESS = 1'd0;
  localparam logic [0:0] REG_ANSWER_TTL = 1'd1;

  localparam logic [7:0] FLAG_RESPONSE = 8'h80;

  typedef enum logic [1:0] {
    KIND_EDIT  = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_DROP  = 2'd2
  } result_kind_e;

  typedef struct packed {
    logic                drop;
    logic [7:0]          flags;
    logic                is_a;
    logic [OFFSET_W-1:0] name_end;
  } job_t;

  typedef struct packed {
    result_kind_e        kind;
    logic [OFFSET_W-1:0] offset;
    logic [7:0]          value;
    logic [LENGTH_W-1:0] length;
    logic                last;
  } result_t;

endpackage

[rtl/dqr_front.sv]
// Byte parser: tracks header flags, walks the first question name and
// classifies each datagram into a job descriptor. Depends on dqr_pkg.
`timescale 1ns / 1ps

module dqr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_datagram_i,
  output logic                job_push_o,
  output dqr_pkg::job_t       job_o
);

  logic [dqr_pkg::CNT_W-1:0]    count_q, count_d;
  logic [7:0]                   flags_q, flags_d;
  logic [dqr_pkg::LBL_W-1:0]    label_q, label_d;
  logic                         found_q, found_d;
  logic                         aborted_q, aborted_d;
  logic [dqr_pkg::OFFSET_W-1:0] nep_q, nep_d;
  logic [15:0]                  qtype_q, qtype_d;

  logic                         in_range;
  logic [dqr_pkg::LBL_W-1:0]    label_sum;
  logic [dqr_pkg::CMP_W-1:0]    pos_ext;
  logic [dqr_pkg::CMP_W-1:0]    nep_ext;
  logic                         drop;

  assign in_range  = count_q < dqr_pkg::CNT_W'(dqr_pkg::MAX_DATAGRAM);
  assign label_sum = label_q + dqr_pkg::LBL_W'(data_byte_i) + dqr_pkg::LBL_W'(1);
  assign pos_ext   = dqr_pkg::CMP_W'(count_q);
  assign nep_ext   = dqr_pkg::CMP_W'(nep_q);

  always_comb begin
    count_d   = count_q;
    flags_d   = flags_q;
    label_d   = label_q;
    found_d   = found_q;
    aborted_d = aborted_q;
    nep_d     = nep_q;
    qtype_d   = qtype_q;
    if (take_i && in_range) begin
      count_d = count_q + dqr_pkg::CNT_W'(1);
      if (count_q == dqr_pkg::CNT_W'(2)) begin
        flags_d = data_byte_i;
      end
      if (!found_q && !aborted_q && dqr_pkg::LBL_W'(count_q) == label_q) begin
        if (data_byte_i == 8'd0) begin
          found_d = 1'b1;
          nep_d   = dqr_pkg::OFFSET_W'(count_q);
        end else begin
          label_d = label_sum;
          if (label_sum >= dqr_pkg::LBL_W'(dqr_pkg::MAX_DATAGRAM)) begin
            aborted_d = 1'b1;
          end
        end
      end else if (found_q) begin
        if (pos_ext == nep_ext + dqr_pkg::CMP_W'(1)) begin
          qtype_d = {data_byte_i, qtype_q[7:0]};
        end else if (pos_ext == nep_ext + dqr_pkg::CMP_W'(2)) begin
          qtype_d = {qtype_q[15:8], data_byte_i};
        end
      end
    end
  end

  assign drop = (count_d < dqr_pkg::CNT_W'(dqr_pkg::HEADER_LEN)) || flags_d[7] ||
                aborted_d || !found_d ||
                (dqr_pkg::CMP_W'(nep_d) + dqr_pkg::CMP_W'(dqr_pkg::QUESTION_TAIL) >
                 dqr_pkg::CMP_W'(count_d));

  assign job_push_o = take_i && end_of_datagram_i;
  assign job_o      = '{drop: drop, flags: flags_d, is_a: (qtype_d == 16'd1),
                        name_end: nep_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      flags_q   <= '0;
      label_q   <= dqr_pkg::LBL_W'(dqr_pkg::HEADER_LEN);
      found_q   <= 1'b0;
      aborted_q <= 1'b0;
      nep_q     <= '0;
      qtype_q   <= '0;
    end else if (take_i) begin
      if (end_of_datagram_i) begin
        count_q   <= '0;
        flags_q   <= '0;
        label_q   <= dqr_pkg::LBL_W'(dqr_pkg::HEADER_LEN);
        found_q   <= 1'b0;
        aborted_q <= 1'b0;
        nep_q     <= '0;
        qtype_q   <= '0;
      end else begin
        count_q   <= count_d;
        flags_q   <= flags_d;
        label_q   <= label_d;
        found_q   <= found_d;
        aborted_q <= aborted_d;
        nep_q     <= nep_d;
        qtype_q   <= qtype_d;
      end
    end
  end

endmodule

[rtl/dqr_job_fifo.sv]
// Short queue of classified datagram jobs between parser and emitter.
// Depends on dqr_pkg.
`timescale 1ns / 1ps

module dqr_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dqr_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output dqr_pkg::job_t data_o
);

  localparam int PTR_W = $clog2(dqr_pkg::JOB_DEPTH);
  localparam int CNT_W = $clog2(dqr_pkg::JOB_DEPTH + 1);

  dqr_pkg::job_t    mem_q [dqr_pkg::JOB_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(dqr_pkg::JOB_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(dqr_pkg::JOB_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(dqr_pkg::JOB_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/dqr_back.sv]
// Result sequencer: expands one job into a drop beat or a run of edits,
// an optional answer record and a reply beat. Depends on dqr_pkg.
`timescale 1ns / 1ps

module dqr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  input  dqr_pkg::job_t               job_i,
  output logic                        job_pop_o,
  input  logic [dqr_pkg::CFG_W-1:0]   answer_address_i,
  input  logic [dqr_pkg::CFG_W-1:0]   answer_ttl_i,
  input  logic                        res_full_i,
  output logic                        res_push_o,
  output dqr_pkg::result_t            res_o
);

  localparam logic [4:0] STEP_HDR_LAST = 5'd7;
  localparam logic [4:0] STEP_ANSWER = 5'd8;
  localparam logic [4:0] STEP_REPLY = 5'd24;

  logic [4:0]                 step_q;
  logic [dqr_pkg::CMP_W-1:0]  qend;
  logic                       append;
  logic [3:0]                 rec_idx;
  logic [7:0]                 rec_byte;
  logic                       fire;

  assign qend    = dqr_pkg::CMP_W'(job_i.name_end) + dqr_pkg::CMP_W'(dqr_pkg::QUESTION_TAIL);
  assign append  = job_i.is_a && (qend + dqr_pkg::CMP_W'(dqr_pkg::ANSWER_LEN) <=
                                  dqr_pkg::CMP_W'(dqr_pkg::MAX_DATAGRAM));
  assign rec_idx = 4'(step_q - STEP_ANSWER);

  always_comb begin
    case (rec_idx)
      4'd0:    rec_byte = 8'hC0;
      4'd1:    rec_byte = 8'h0C;
      4'd3:    rec_byte = 8'h01;
      4'd5:    rec_byte = 8'h01;
      4'd6:    rec_byte = answer_ttl_i[31:24];
      4'd7:    rec_byte = answer_ttl_i[23:16];
      4'd8:    rec_byte = answer_ttl_i[15:8];
      4'd9:    rec_byte = answer_ttl_i[7:0];
      4'd11:   rec_byte = 8'h04;
      4'd12:   rec_byte = answer_address_i[31:24];
      4'd13:   rec_byte = answer_address_i[23:16];
      4'd14:   rec_byte = answer_address_i[15:8];
      4'd15:   rec_byte = answer_address_i[7:0];
      default: rec_byte = 8'h00;
    endcase
  end

  always_comb begin
    res_o = '{kind: dqr_pkg::KIND_EDIT, default: '0};
    if (job_i.drop) begin
      res_o.kind = dqr_pkg::KIND_DROP;
      res_o.last = 1'b1;
    end else begin
      case (step_q) inside
        5'd0: begin
          res_o.offset = dqr_pkg::OFFSET_W'(2);
          res_o.value  = job_i.flags | dqr_pkg::FLAG_RESPONSE;
        end
        5'd1: begin
          res_o.offset = dqr_pkg::OFFSET_W'(3);
          res_o.value  = dqr_pkg::FLAG_RESPONSE;
        end
        5'd2: begin
          res_o.offset = dqr_pkg::OFFSET_W'(6);
        end
        5'd3: begin
          res_o.offset = dqr_pkg::OFFSET_W'(7);
          res_o.value  = {7'd0, job_i.is_a};
        end
        [5'd4:5'd7]: begin
          res_o.offset = dqr_pkg::OFFSET_W'(step_q) + dqr_pkg::OFFSET_W'(4);
        end
        [5'd8:5'd23]: begin
          res_o.offset = dqr_pkg::OFFSET_W'(qend + dqr_pkg::CMP_W'(rec_idx));
          res_o.value  = rec_byte;
        end
        default: begin
          res_o.kind   = dqr_pkg::KIND_REPLY;
          res_o.length = dqr_pkg::LENGTH_W'(qend + (append ?
                           dqr_pkg::CMP_W'(dqr_pkg::ANSWER_LEN) : '0));
          res_o.last   = 1'b1;
        end
      endcase
    end
  end

  assign fire       = job_valid_i && !res_full_i;
  assign res_push_o = fire;
  assign job_pop_o  = fire && res_o.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (fire) begin
      if (res_o.last) begin
        step_q <= '0;
      end else if (step_q == STEP_HDR_LAST && !append) begin
        step_q <= STEP_REPLY;
      end else begin
        step_q <= step_q + 5'd1;
      end
    end
  end

endmodule

[rtl/dqr_result_fifo.sv]
// Output queue of result beats presented on the block's pop side.
// Depends on dqr_pkg.
`timescale 1ns / 1ps

module dqr_result_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dqr_pkg::result_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output dqr_pkg::result_t data_o
);

  localparam int PTR_W = $clog2(dqr_pkg::RES_DEPTH);
  localparam int CNT_W = $clog2(dqr_pkg::RES_DEPTH + 1);

  dqr_pkg::result_t mem_q [dqr_pkg::RES_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(dqr_pkg::RES_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(dqr_pkg::RES_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(dqr_pkg::RES_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/dns_query_reply_rewriter_unit.sv]
// Top level of the DNS query reply rewriter: configuration registers,
// parser, job queue, result sequencer and output queue. Depends on dqr_pkg.
//
//   Channel   Handshake        Payload
//   input     push / full      data_byte_i, end_of_datagram_i
//   result    pop / empty      result_kind_o, edit_offset_o, edit_value_o,
//                              reply_length_o, run_last_o
//   config    cfg_we_i         cfg_index_i, cfg_wdata_i
//
// The parser takes one byte beat per cycle while the job queue has room.
// Each datagram expands into 1 drop beat or 9 to 25 result beats, one per
// cycle while the output queue has room; the queues decouple both sides.
// Reset clears all parser state and loads the default address and TTL.
`timescale 1ns / 1ps

module dns_query_reply_rewriter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [7:0]                        data_byte_i,
  input  logic                              end_of_datagram_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [1:0]                        result_kind_o,
  output logic [dqr_pkg::OFFSET_W-1:0]      edit_offset_o,
  output logic [7:0]                        edit_value_o,
  output logic [dqr_pkg::LENGTH_W-1:0]      reply_length_o,
  output logic                              run_last_o,
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_index_i,
  input  logic [dqr_pkg::CFG_W-1:0]         cfg_wdata_i
);

  logic [dqr_pkg::CFG_W-1:0] address_q, ttl_q;

  logic             take;
  logic             job_push, job_full, job_empty, job_pop;
  dqr_pkg::job_t    job_in, job_head;
  logic             res_push, res_full;
  dqr_pkg::result_t res_in, res_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_q <= 32'hC0A8_0401;
      ttl_q     <= 32'd60;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dqr_pkg::REG_ANSWER_ADDRESS: address_q <= cfg_wdata_i;
        dqr_pkg::REG_ANSWER_TTL:     ttl_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign full = job_full;
  assign take = push && !job_full;

  dqr_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .take_i            (take),
    .data_byte_i       (data_byte_i),
    .end_of_datagram_i (end_of_datagram_i),
    .job_push_o        (job_push),
    .job_o             (job_in)
  );

  dqr_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_head)
  );

  dqr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (!job_empty),
    .job_i            (job_head),
    .job_pop_o        (job_pop),
    .answer_address_i (address_q),
    .answer_ttl_i     (ttl_q),
    .res_full_i       (res_full),
    .res_push_o       (res_push),
    .res_o            (res_in)
  );

  dqr_result_fifo u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_head)
  );

  assign result_kind_o  = res_head.kind;
  assign edit_offset_o  = res_head.offset;
  assign edit_value_o   = res_head.value;
  assign reply_length_o = res_head.length;
  assign run_last_o     = res_head.last;

endmodule

[tb/dns_query_reply_rewriter_unit_test.sv]
// Self-checking testbench for dns_query_reply_rewriter_unit: streams DNS datagrams byte by byte
// and checks every edit, reply and drop beat against an in-bench rewrite predictor.
// Depends on dqr_pkg and the dns_query_reply_rewriter_unit RTL.
`timescale 1ns / 1ps

module dns_query_reply_rewriter_unit_test;

  localparam int QUIET_CYCLES = 16;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         push = 1'b0;
  logic                         full;
  logic [7:0]                   data_byte_i = '0;
  logic                         end_of_datagram_i = 1'b0;
  logic                         empty;
  logic                         pop = 1'b0;
  logic [1:0]                   result_kind_o;
  logic [dqr_pkg::OFFSET_W-1:0] edit_offset_o;
  logic [7:0]                   edit_value_o;
  logic [dqr_pkg::LENGTH_W-1:0] reply_length_o;
  logic                         run_last_o;
  logic                         cfg_we_i = 1'b0;
  logic [0:0]                   cfg_index_i = dqr_pkg::REG_ANSWER_ADDRESS;
  logic [dqr_pkg::CFG_W-1:0]    cfg_wdata_i = '0;

  dns_query_reply_rewriter_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .data_byte_i       (data_byte_i),
    .end_of_datagram_i (end_of_datagram_i),
    .empty             (empty),
    .pop               (pop),
    .result_kind_o     (result_kind_o),
    .edit_offset_o     (edit_offset_o),
    .edit_value_o      (edit_value_o),
    .reply_length_o    (reply_length_o),
    .run_last_o        (run_last_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  logic [dqr_pkg::CFG_W-1:0]    answer_addr = 32'hC0A80401;
  logic [dqr_pkg::CFG_W-1:0]    answer_ttl = 32'd60;
  logic [dqr_pkg::CNT_W-1:0]    rx_count = '0;
  logic [7:0]                   rx_flags = '0;
  logic [dqr_pkg::LBL_W-1:0]    next_label = dqr_pkg::LBL_W'(dqr_pkg::HEADER_LEN);
  logic                         name_done = 1'b0;
  logic                         walk_abort = 1'b0;
  logic [dqr_pkg::OFFSET_W-1:0] name_end = '0;
  logic [15:0]                  qtype = '0;

  dqr_pkg::result_t rewrite_q[$];
  logic [7:0]       dgram[$];
  int               error_count = 0;
  int               send_idle_pct = 0;
  int               pop_stall_pct = 0;
  int               rx_hold_cycles = 0;

  function automatic void queue_rewrite(input dqr_pkg::result_kind_e kind, input int off,
                                        input logic [7:0] val, input int len,
                                        input logic last);
    dqr_pkg::result_t r;
    r.kind   = kind;
    r.offset = off[dqr_pkg::OFFSET_W-1:0];
    r.value  = val;
    r.length = len[dqr_pkg::LENGTH_W-1:0];
    r.last   = last;
    rewrite_q.push_back(r);
  endfunction

  task automatic track_query_byte(input logic [7:0] b, input logic last);
    int           qend;
    int           len;
    logic         is_a;
    logic [127:0] rec;
    if (rx_count < dqr_pkg::MAX_DATAGRAM) begin
      if (rx_count == 2) rx_flags = b;
      if (!name_done && !walk_abort && rx_count == next_label) begin
        if (b == 8'd0) begin
          name_done = 1'b1;
          name_end  = rx_count[dqr_pkg::OFFSET_W-1:0];
        end else begin
          next_label = next_label + dqr_pkg::LBL_W'(b) + dqr_pkg::LBL_W'(1);
          if (next_label >= dqr_pkg::MAX_DATAGRAM) walk_abort = 1'b1;
        end
      end else if (name_done) begin
        if (rx_count == name_end + 1) qtype[15:8] = b;
        else if (rx_count == name_end + 2) qtype[7:0] = b;
      end
      rx_count = rx_count + dqr_pkg::CNT_W'(1);
    end
    if (last) begin
      qend = int'(name_end) + dqr_pkg::QUESTION_TAIL;
      if (rx_count < dqr_pkg::HEADER_LEN || (rx_flags & dqr_pkg::FLAG_RESPONSE) != 0 ||
          walk_abort || !name_done || qend > rx_count) begin
        queue_rewrite(dqr_pkg::KIND_DROP, 0, 8'd0, 0, 1'b1);
      end else begin
        is_a = (qtype == 16'h0001);
        len  = qend;
        queue_rewrite(dqr_pkg::KIND_EDIT, 2, rx_flags | dqr_pkg::FLAG_RESPONSE, 0, 1'b0);
        queue_rewrite(dqr_pkg::KIND_EDIT, 3, 8'h80, 0, 1'b0);
        queue_rewrite(dqr_pkg::KIND_EDIT, 6, 8'd0, 0, 1'b0);
        queue_rewrite(dqr_pkg::KIND_EDIT, 7, {7'd0, is_a}, 0, 1'b0);
        for (int i = 8; i < dqr_pkg::HEADER_LEN; i++) begin
          queue_rewrite(dqr_pkg::KIND_EDIT, i, 8'd0, 0, 1'b0);
        end
        if (is_a && qend + dqr_pkg::ANSWER_LEN <= dqr_pkg::MAX_DATAGRAM) begin
          rec = {8'hC0, 8'h0C, 16'h0001, 16'h0001, answer_ttl, 16'h0004, answer_addr};
          for (int i = 0; i < dqr_pkg::ANSWER_LEN; i++) begin
            queue_rewrite(dqr_pkg::KIND_EDIT, qend + i, rec[127 - 8*i -: 8], 0, 1'b0);
          end
          len = qend + dqr_pkg::ANSWER_LEN;
        end
        queue_rewrite(dqr_pkg::KIND_REPLY, 0, 8'd0, len, 1'b1);
      end
      rx_count   = '0;
      rx_flags   = '0;
      next_label = dqr_pkg::LBL_W'(dqr_pkg::HEADER_LEN);
      name_done  = 1'b0;
      walk_abort = 1'b0;
      name_end   = '0;
      qtype      = '0;
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles = rx_hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    dqr_pkg::result_t want;
    if (rst_ni && pop && !empty) begin
      if (rewrite_q.size() == 0) begin
        $error("unexpected result beat: kind %0d offset %0d", result_kind_o, edit_offset_o);
        error_count++;
      end else begin
        want = rewrite_q.pop_front();
        if (result_kind_o !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, result_kind_o);
          error_count++;
        end
        if (edit_offset_o !== want.offset) begin
          $error("edit_offset: expected %0d, got %0d", want.offset, edit_offset_o);
          error_count++;
        end
        if (edit_value_o !== want.value) begin
          $error("edit_value: expected 0x%02h, got 0x%02h", want.value, edit_value_o);
          error_count++;
        end
        if (reply_length_o !== want.length) begin
          $error("reply_length: expected %0d, got %0d", want.length, reply_length_o);
          error_count++;
        end
        if (run_last_o !== want.last) begin
          $error("run_last: expected %0d, got %0d", want.last, run_last_o);
          error_count++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push              <= 1'b1;
    data_byte_i       <= b;
    end_of_datagram_i <= last;
    do @(posedge clk_i); while (full);
    track_query_byte(b, last);
  endtask

  task automatic send_dgram();
    for (int i = 0; i < dgram.size(); i++) send_byte(dgram[i], i == dgram.size() - 1);
  endtask

  task automatic wait_rewrites_done();
    @(negedge clk_i);
    push <= 1'b0;
    while (rewrite_q.size() != 0) @(negedge clk_i);
    repeat (QUIET_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_answer_reg(input logic [0:0] idx,
                                  input logic [dqr_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    if (idx == dqr_pkg::REG_ANSWER_ADDRESS) answer_addr = val;
    else answer_ttl = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic put_header(input logic [7:0] flags);
    dgram.push_back(8'($urandom));
    dgram.push_back(8'($urandom));
    dgram.push_back(flags);
    repeat (9) dgram.push_back(8'($urandom));
  endtask

  task automatic put_label(input int len);
    dgram.push_back(len[7:0]);
    repeat (len) dgram.push_back(8'($urandom));
  endtask

  task automatic put_question(input logic [15:0] qt);
    dgram.push_back(8'd0);
    dgram.push_back(qt[15:8]);
    dgram.push_back(qt[7:0]);
    dgram.push_back(8'h00);
    dgram.push_back(8'h01);
  endtask

  task automatic build_query(input logic [7:0] flags, input int nlab, input logic [15:0] qt);
    dgram.delete();
    put_header(flags);
    repeat (nlab) put_label($urandom_range(4, 1));
    put_question(qt);
  endtask

  task automatic build_random_dgram();
    int          pick;
    logic [7:0]  flags;
    logic [15:0] qt;
    pick = $urandom_range(99);
    if (pick < 10) begin
      dgram.delete();
      repeat ($urandom_range(40, 1)) dgram.push_back(8'($urandom));
    end else begin
      flags = 8'($urandom) & ~dqr_pkg::FLAG_RESPONSE;
      if (pick < 18) flags = flags | dqr_pkg::FLAG_RESPONSE;
      qt = $urandom_range(1) ? 16'h0001 : 16'($urandom);
      build_query(flags, $urandom_range(3), qt);
      if ($urandom_range(3) == 0) repeat ($urandom_range(6, 1)) dgram.push_back(8'($urandom));
      if (pick >= 18 && pick < 30) begin
        repeat ($urandom_range(dgram.size() - 1, 1)) void'(dgram.pop_back());
      end
    end
  endtask

  task automatic test_query_directed();
    build_query(8'h01, 2, 16'h0001);
    send_dgram();
    build_query(8'h7F, 0, 16'h001C);
    send_dgram();
    build_query(8'h00, 0, 16'h0100);
    send_dgram();
    build_query(8'h10, 0, 16'h0101);
    send_dgram();
    build_query(8'h00, 0, 16'h0001);
    send_dgram();
    build_query(8'h80, 0, 16'h0001);
    send_dgram();
    build_query(8'hFF, 1, 16'h0001);
    send_dgram();
    dgram.delete();
    put_header(8'h00);
    void'(dgram.pop_back());
    send_dgram();
    send_byte(8'hFF, 1'b1);
    dgram.delete();
    put_header(8'h00);
    send_dgram();
    build_query(8'h00, 0, 16'h0001);
    void'(dgram.pop_back());
    void'(dgram.pop_back());
    send_dgram();
    build_query(8'h00, 0, 16'h0001);
    void'(dgram.pop_back());
    send_dgram();
    build_query(8'h00, 1, 16'h0001);
    repeat (3) dgram.push_back(8'($urandom));
    send_dgram();
    wait_rewrites_done();
  endtask

  task automatic test_answer_registers();
    logic [dqr_pkg::CFG_W-1:0] addr_v[3];
    logic [dqr_pkg::CFG_W-1:0] ttl_v[3];
    addr_v = '{32'h0000_0000, 32'hFFFF_FFFF, 32'($urandom)};
    ttl_v  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'($urandom)};
    for (int s = 0; s < 3; s++) begin
      write_answer_reg(dqr_pkg::REG_ANSWER_ADDRESS, addr_v[s]);
      write_answer_reg(dqr_pkg::REG_ANSWER_TTL, ttl_v[s]);
      build_query(8'($urandom) & ~dqr_pkg::FLAG_RESPONSE, $urandom_range(1), 16'h0001);
      send_dgram();
      wait_rewrites_done();
    end
  endtask

  task automatic test_random_traffic(input int idle, input int stall,
                                     input logic [dqr_pkg::CFG_W-1:0] addr,
                                     input logic [dqr_pkg::CFG_W-1:0] ttl);
    int sent;
    write_answer_reg(dqr_pkg::REG_ANSWER_ADDRESS, addr);
    write_answer_reg(dqr_pkg::REG_ANSWER_TTL, ttl);
    send_idle_pct = idle;
    pop_stall_pct = stall;
    sent = 0;
    while (sent < 30) begin
      build_random_dgram();
      send_dgram();
      sent += dgram.size();
    end
    wait_rewrites_done();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    pop_stall_pct  = 0;
    rx_hold_cycles = 400;
    repeat (5) begin
      build_query(8'h00, 0, 16'h0001);
      send_dgram();
    end
    wait_rewrites_done();
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_query_directed();
    test_answer_registers();
    test_random_traffic(0, 0, 32'h0000_0000, 32'hFFFF_FFFF);
    test_random_traffic(54, 0, 32'($urandom), 32'($urandom));
    test_random_traffic(0, 54, 32'hFFFF_FFFF, 32'h0000_0000);
    test_random_traffic(22, 22, 32'($urandom), 32'($urandom));
    test_backpressure();
    wait_rewrites_done();
    if (error_count == 0) begin
      $display("dns_query_reply_rewriter_unit_test: clean");
    end else begin
      $display("dns_query_reply_rewriter_unit_test: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("dns_query_reply_rewriter_unit_test: errors");
    $finish;
  end

endmodule
